/* rtl/can_register_poll_sequencer_defines.svh */
// ---------------------------------------------------------------------------
// can_register_poll_sequencer_defines
// Assertion macros shared by the poll sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef CAN_REGISTER_POLL_SEQUENCER_DEFINES_SVH
`define CAN_REGISTER_POLL_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/crps_pkg.sv */
// ---------------------------------------------------------------------------
// crps_pkg
// Constants and lookup functions for the CAN register poll sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package crps_pkg;

    localparam int unsigned STEP_COUNT       = 12;
    localparam int unsigned WRITE_FIRST_STEP = 8;

    localparam int unsigned ID_W    = 11;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned WCNT_W  = 9;
    localparam int unsigned CIDX_W  = 3;

    localparam logic [ID_W-1:0] ID_GROUP_LO = 11'h600;
    localparam logic [ID_W-1:0] ID_GROUP_HI = 11'h610;

    localparam logic [STEP_W-1:0] STEP_LAST = 4'(STEP_COUNT - 1);
    localparam logic [STEP_W-1:0] STEP_WR0  = 4'(WRITE_FIRST_STEP);

    localparam logic [WCNT_W-1:0] WCNT_MAX = '1;

    localparam logic [2:0] TX_LEN_READ  = 3'd0;
    localparam logic [2:0] TX_LEN_WRITE = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CMD     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_POWER   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_VOLTAGE = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_CURRENT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT = 3'd4;

    localparam logic [15:0] CMD_RST     = 16'd2;
    localparam logic [15:0] POWER_RST   = 16'd5000;
    localparam logic [15:0] VOLTAGE_RST = 16'd2400;
    localparam logic [15:0] CURRENT_RST = 16'd500;
    localparam logic [7:0]  TIMEOUT_RST = 8'd100;

    // identifier sent at each step; out-of-range steps map like step 0
    function automatic logic [ID_W-1:0] step_id(input logic [STEP_W-1:0] s);
        logic [ID_W-1:0] id;
        case (s)
            4'd0, 4'd8:  id = ID_GROUP_LO;
            4'd1, 4'd9:  id = ID_GROUP_LO + 11'd1;
            4'd2, 4'd10: id = ID_GROUP_LO + 11'd2;
            4'd3, 4'd11: id = ID_GROUP_LO + 11'd3;
            4'd4:        id = ID_GROUP_HI;
            4'd5:        id = ID_GROUP_HI + 11'd1;
            4'd6:        id = ID_GROUP_HI + 11'd2;
            4'd7:        id = ID_GROUP_HI + 11'd3;
            default:     id = ID_GROUP_LO;
        endcase
        return id;
    endfunction

endpackage

`default_nettype wire

/* rtl/can_register_poll_sequencer.sv */
// Latency: a result beat is valid the cycle after its input beat is accepted.
// Throughput: one item per cycle; the output register lets a new item in
// whenever the held result is taken in the same cycle or the register is empty.
// Reset (rst_n low, asynchronous): sequencer at step 0, ready to send, reply
// flag and wait count clear, setpoints and timeout at their default values.
// ---------------------------------------------------------------------------
// can_register_poll_sequencer
// Polls a power module over CAN: remote reads of eight status registers,
// then writes of four setpoints, with reply matching and timeout resend.
// Received data frames are decoded into up to three words.
// ---------------------------------------------------------------------------
`default_nettype none
`include "can_register_poll_sequencer_defines.svh"

module can_register_poll_sequencer
    import crps_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [15:0]         cfg_data,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                mode,
    input  wire logic [ID_W-1:0]     rx_id,
    input  wire logic                rx_remote,
    input  wire logic [15:0]         rx_word_a,
    input  wire logic [15:0]         rx_word_b,
    input  wire logic [15:0]         rx_word_c,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     tx_valid,
    output logic [ID_W-1:0]          tx_id,
    output logic                     tx_remote,
    output logic [2:0]               tx_length,
    output logic [31:0]              tx_payload,
    output logic                     decode_valid,
    output logic [2:0]               decode_group,
    output logic [15:0]              word_a,
    output logic [15:0]              word_b,
    output logic [15:0]              word_c
);

    // configuration
    logic [15:0] cmd_reg, power_reg, voltage_reg, current_reg;
    logic [7:0]  timeout_reg;

    // sequencer state
    logic              waiting_reg,    waiting_next;
    logic [STEP_W-1:0] step_reg,       step_next;
    logic [ID_W-1:0]   pending_id_reg, pending_id_next;
    logic              reply_seen_reg, reply_seen_next;
    logic [WCNT_W-1:0] wait_count_reg, wait_count_next;

    // result register
    logic              out_valid_reg;
    logic              tx_valid_reg,     tx_valid_next;
    logic [ID_W-1:0]   tx_id_reg,        tx_id_next;
    logic              tx_remote_reg,    tx_remote_next;
    logic [2:0]        tx_length_reg,    tx_length_next;
    logic [31:0]       tx_payload_reg,   tx_payload_next;
    logic              decode_valid_reg, decode_valid_next;
    logic [2:0]        decode_group_reg, decode_group_next;
    logic [15:0]       word_a_reg,       word_a_next;
    logic [15:0]       word_b_reg,       word_b_next;
    logic [15:0]       word_c_reg,       word_c_next;

    logic              in_fire;
    logic [STEP_W-1:0] step_norm;
    logic [ID_W-1:0]   send_id;
    logic [15:0]       wr_value;
    logic [WCNT_W-1:0] wcnt_upd;
    logic              in_lo_grp, in_hi_grp;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    assign step_norm = (step_reg <= STEP_LAST) ? step_reg : '0;
    assign send_id   = step_id(step_norm);

    always_comb
    begin
        case (step_norm)
            4'd8:    wr_value = cmd_reg;
            4'd9:    wr_value = power_reg;
            4'd10:   wr_value = voltage_reg;
            default: wr_value = current_reg;
        endcase
    end

    assign in_lo_grp = (rx_id[ID_W-1:2] == ID_GROUP_LO[ID_W-1:2]);
    assign in_hi_grp = (rx_id[ID_W-1:2] == ID_GROUP_HI[ID_W-1:2]);

    always_comb
    begin
        waiting_next      = waiting_reg;
        step_next         = step_reg;
        pending_id_next   = pending_id_reg;
        reply_seen_next   = reply_seen_reg;
        wait_count_next   = wait_count_reg;
        wcnt_upd          = wait_count_reg;

        tx_valid_next     = 1'b0;
        tx_id_next        = '0;
        tx_remote_next    = 1'b0;
        tx_length_next    = TX_LEN_READ;
        tx_payload_next   = '0;
        decode_valid_next = 1'b0;
        decode_group_next = '0;
        word_a_next       = '0;
        word_b_next       = '0;
        word_c_next       = '0;

        if (mode) begin
            // every frame overwrites the reply flag
            reply_seen_next = (rx_id == pending_id_reg);
            if (!rx_remote && (in_lo_grp || in_hi_grp)) begin
                decode_valid_next = 1'b1;
                decode_group_next = {in_hi_grp, rx_id[1:0]};
                word_a_next       = rx_word_a;
                if (in_hi_grp)
                    word_b_next = rx_word_b;
                if (in_hi_grp && rx_id[1:0] != 2'd0)
                    word_c_next = rx_word_c;
            end
        end else if (!waiting_reg) begin
            wait_count_next = '0;
            waiting_next    = 1'b1;
            pending_id_next = send_id;
            tx_valid_next   = 1'b1;
            tx_id_next      = send_id;
            if (step_norm < STEP_WR0) begin
                tx_remote_next = 1'b1;
            end else begin
                tx_length_next  = TX_LEN_WRITE;
                tx_payload_next = {wr_value, 16'h0000};
            end
        end else begin
            if (reply_seen_reg) begin
                reply_seen_next = 1'b0;
                step_next       = (step_norm == STEP_LAST) ? '0 : step_norm + 4'd1;
                waiting_next    = 1'b0;
            end else if (wait_count_reg != WCNT_MAX) begin
                wcnt_upd = wait_count_reg + 9'd1;
            end
            wait_count_next = wcnt_upd;
            if (wcnt_upd > {1'b0, timeout_reg})
                waiting_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_reg        <= CMD_RST;
            power_reg      <= POWER_RST;
            voltage_reg    <= VOLTAGE_RST;
            current_reg    <= CURRENT_RST;
            timeout_reg    <= TIMEOUT_RST;
            waiting_reg    <= 1'b0;
            step_reg       <= '0;
            pending_id_reg <= '0;
            reply_seen_reg <= 1'b0;
            wait_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CMD:     cmd_reg     <= cfg_data;
                    CFG_POWER:   power_reg   <= cfg_data;
                    CFG_VOLTAGE: voltage_reg <= cfg_data;
                    CFG_CURRENT: current_reg <= cfg_data;
                    CFG_TIMEOUT: timeout_reg <= cfg_data[7:0];
                    default:     ;
                endcase
            end
            if (in_fire) begin
                waiting_reg    <= waiting_next;
                step_reg       <= step_next;
                pending_id_reg <= pending_id_next;
                reply_seen_reg <= reply_seen_next;
                wait_count_reg <= wait_count_next;
                out_valid_reg  <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // result payload, loaded on each accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            tx_valid_reg     <= tx_valid_next;
            tx_id_reg        <= tx_id_next;
            tx_remote_reg    <= tx_remote_next;
            tx_length_reg    <= tx_length_next;
            tx_payload_reg   <= tx_payload_next;
            decode_valid_reg <= decode_valid_next;
            decode_group_reg <= decode_group_next;
            word_a_reg       <= word_a_next;
            word_b_reg       <= word_b_next;
            word_c_reg       <= word_c_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_id        = tx_id_reg;
    assign tx_remote    = tx_remote_reg;
    assign tx_length    = tx_length_reg;
    assign tx_payload   = tx_payload_reg;
    assign decode_valid = decode_valid_reg;
    assign decode_group = decode_group_reg;
    assign word_a       = word_a_reg;
    assign word_b       = word_b_reg;
    assign word_c       = word_c_reg;

    `CRPS_ASSERT_NOW(a_step_range, 1'b1, step_reg <= STEP_LAST, "step index out of range")
    `CRPS_ASSERT_NEXT(a_send_waits, in_fire && !mode && !waiting_reg, waiting_reg,
        "send did not enter wait")
    `CRPS_ASSERT_NEXT(a_mismatch_clears, in_fire && mode && rx_id != pending_id_reg,
        !reply_seen_reg, "non-matching frame left reply flag set")
    `CRPS_ASSERT_NOW(a_one_kind, out_valid_reg, !(tx_valid_reg && decode_valid_reg),
        "result carries both a send and a decode")
    `CRPS_ASSERT_NOW(a_read_empty, out_valid_reg && tx_valid_reg && tx_remote_reg,
        tx_length_reg == TX_LEN_READ && tx_payload_reg == 32'h0, "remote read with data")

endmodule

`default_nettype wire

/* tb/poll_result_checker.sv */
// ---------------------------------------------------------------------------
// poll_result_checker
// Watches the register, input and result channels of the poll sequencer,
// predicts every result beat from its own copy of the sequencer state and
// compares each accepted result beat field by field.
// ---------------------------------------------------------------------------
package poll_tb_pkg;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

endpackage

module poll_result_checker
    import crps_pkg::*;
    import poll_tb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [15:0]         cfg_data,

    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                mode,
    input  logic [ID_W-1:0]     rx_id,
    input  logic                rx_remote,
    input  logic [15:0]         rx_word_a,
    input  logic [15:0]         rx_word_b,
    input  logic [15:0]         rx_word_c,

    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                tx_valid,
    input  logic [ID_W-1:0]     tx_id,
    input  logic                tx_remote,
    input  logic [2:0]          tx_length,
    input  logic [31:0]         tx_payload,
    input  logic                decode_valid,
    input  logic [2:0]          decode_group,
    input  logic [15:0]         word_a,
    input  logic [15:0]         word_b,
    input  logic [15:0]         word_c,

    output int                  mismatch_count,
    output int                  due_count,
    output logic [ID_W-1:0]     reply_id
);

    localparam int GROUP_SIZE = 4;

    typedef struct packed {
        logic             tx_valid;
        logic [ID_W-1:0]  tx_id;
        logic             tx_remote;
        logic [2:0]       tx_length;
        logic [31:0]      tx_payload;
        logic             decode_valid;
        logic [2:0]       decode_group;
        logic [15:0]      word_a;
        logic [15:0]      word_b;
        logic [15:0]      word_c;
    } poll_result_t;

    logic [15:0]        cmd_set;
    logic [15:0]        power_level;
    logic [15:0]        voltage_level;
    logic [15:0]        current_level;
    logic [7:0]         timeout_set;

    logic               waiting;
    logic [STEP_W-1:0]  step_at;
    logic [ID_W-1:0]    pending_id;
    logic               reply_seen;
    logic [WCNT_W-1:0]  wait_ticks;

    poll_result_t       due_beats[$];

    function automatic logic [ID_W-1:0] id_of_step(input logic [STEP_W-1:0] s);
        if (s < WRITE_FIRST_STEP)
        begin
            if (s < GROUP_SIZE)
                return ID_GROUP_LO + ID_W'(s);
            return ID_GROUP_HI + ID_W'(s - GROUP_SIZE);
        end
        return ID_GROUP_LO + ID_W'(s - STEP_WR0);
    endfunction

    function automatic logic [15:0] setpoint_of_step(input logic [STEP_W-1:0] s);
        case (s - STEP_WR0)
            4'd0:    return cmd_set;
            4'd1:    return power_level;
            4'd2:    return voltage_level;
            default: return current_level;
        endcase
    endfunction

    function automatic poll_result_t predict_beat(input logic md,
                                                  input logic [ID_W-1:0] id,
                                                  input logic rem,
                                                  input logic [15:0] a,
                                                  input logic [15:0] b,
                                                  input logic [15:0] c);
        poll_result_t      r;
        logic [STEP_W-1:0] s;
        logic [2:0]        grp;
        logic              known;
        r = '0;
        if (md == MODE_FRAME)
        begin
            // any frame overwrites the reply flag, matching or not
            reply_seen = (pending_id == id);
            known = 1'b1;
            grp = '0;
            if (id >= ID_GROUP_LO && id < ID_GROUP_LO + GROUP_SIZE)
                grp = 3'(id - ID_GROUP_LO);
            else if (id >= ID_GROUP_HI && id < ID_GROUP_HI + GROUP_SIZE)
                grp = 3'(GROUP_SIZE) + 3'(id - ID_GROUP_HI);
            else
                known = 1'b0;
            if (known && !rem)
            begin
                r.decode_valid = 1'b1;
                r.decode_group = grp;
                r.word_a = a;
                if (grp >= 3'd4)
                    r.word_b = b;
                if (grp >= 3'd5)
                    r.word_c = c;
            end
        end
        else
        begin
            s = (step_at < STEP_COUNT) ? step_at : '0;
            if (!waiting)
            begin
                r.tx_valid = 1'b1;
                r.tx_id = id_of_step(s);
                pending_id = r.tx_id;
                wait_ticks = '0;
                waiting = 1'b1;
                if (s < WRITE_FIRST_STEP)
                begin
                    r.tx_remote = 1'b1;
                    r.tx_length = TX_LEN_READ;
                end
                else
                begin
                    r.tx_length = TX_LEN_WRITE;
                    r.tx_payload = {setpoint_of_step(s), 16'h0000};
                end
            end
            else
            begin
                // a reply wins over the timeout count
                if (reply_seen)
                begin
                    reply_seen = 1'b0;
                    step_at = (s == STEP_LAST) ? '0 : s + 4'd1;
                    waiting = 1'b0;
                end
                else if (wait_ticks != WCNT_MAX)
                    wait_ticks = wait_ticks + 1'b1;
                if (wait_ticks > {1'b0, timeout_set})
                    waiting = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_set = CMD_RST;
            power_level = POWER_RST;
            voltage_level = VOLTAGE_RST;
            current_level = CURRENT_RST;
            timeout_set = TIMEOUT_RST;
            waiting = 1'b0;
            step_at = '0;
            pending_id = '0;
            reply_seen = 1'b0;
            wait_ticks = '0;
            due_beats.delete();
            mismatch_count = 0;
            due_count = 0;
            reply_id = '0;
        end
        else
        begin : watch
            poll_result_t want;
            // a result beat never belongs to the input beat of the same edge
            if (out_valid && out_ready)
            begin
                if (due_beats.size() == 0)
                begin
                    $display("%0t: stray beat, expected nothing, got tx %0b/%0h dec %0b/%0h",
                             $time, tx_valid, tx_id, decode_valid, decode_group);
                    mismatch_count++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
                    check_field("tx_id", 32'(want.tx_id), 32'(tx_id));
                    check_field("tx_remote", 32'(want.tx_remote), 32'(tx_remote));
                    check_field("tx_length", 32'(want.tx_length), 32'(tx_length));
                    check_field("tx_payload", want.tx_payload, tx_payload);
                    check_field("decode_valid", 32'(want.decode_valid), 32'(decode_valid));
                    check_field("decode_group", 32'(want.decode_group), 32'(decode_group));
                    check_field("word_a", 32'(want.word_a), 32'(word_a));
                    check_field("word_b", 32'(want.word_b), 32'(word_b));
                    check_field("word_c", 32'(want.word_c), 32'(word_c));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CMD:     cmd_set = cfg_data;
                    CFG_POWER:   power_level = cfg_data;
                    CFG_VOLTAGE: voltage_level = cfg_data;
                    CFG_CURRENT: current_level = cfg_data;
                    CFG_TIMEOUT: timeout_set = cfg_data[7:0];
                    default:     ;
                endcase
            end
            if (in_valid && in_ready)
                due_beats.push_back(predict_beat(mode, rx_id, rx_remote,
                                                 rx_word_a, rx_word_b, rx_word_c));
            due_count = due_beats.size();
            reply_id = pending_id;
        end
    end

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Drives poll ticks and received frames into the poll sequencer through
// several register settings and idle patterns; the checker predicts and
// compares every result beat.
// ---------------------------------------------------------------------------
module testbench;

    import crps_pkg::*;
    import poll_tb_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int NO_EVENT     = -1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = CFG_CMD;
    logic [15:0]         cfg_data = '0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                mode = MODE_TICK;
    logic [ID_W-1:0]     rx_id = '0;
    logic                rx_remote = 1'b0;
    logic [15:0]         rx_word_a = '0;
    logic [15:0]         rx_word_b = '0;
    logic [15:0]         rx_word_c = '0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                tx_valid;
    logic [ID_W-1:0]     tx_id;
    logic                tx_remote;
    logic [2:0]          tx_length;
    logic [31:0]         tx_payload;
    logic                decode_valid;
    logic [2:0]          decode_group;
    logic [15:0]         word_a;
    logic [15:0]         word_b;
    logic [15:0]         word_c;

    int                  mismatch_count;
    int                  due_count;
    logic [ID_W-1:0]     reply_id;

    int                  send_gap_pct = 22;
    int                  take_gap_pct = 47;
    int                  hold_asked = 0;
    int                  hold_done = 0;
    int                  hold_left = 0;
    int                  quiet = 0;

    always #1 clk = ~clk;

    can_register_poll_sequencer dut (.*);

    poll_result_checker result_check (.*);

    // receiver side: random stalls, plus a long hold when asked
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_asked != hold_done)
        begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= take_gap_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic logic [ID_W-1:0] group_id(input int unsigned g);
        if (g < 4)
            return ID_GROUP_LO + ID_W'(g);
        return ID_GROUP_HI + ID_W'(g - 4);
    endfunction

    task automatic send_item(input logic md, input logic [ID_W-1:0] id, input logic rem,
                             input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        mode <= md;
        rx_id <= id;
        rx_remote <= rem;
        rx_word_a <= a;
        rx_word_b <= b;
        rx_word_c <= c;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [ID_W-1:0] id, input logic rem);
        send_item(MODE_FRAME, id, rem, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // frame fields are don't-care on a tick, so they carry noise
    task automatic send_tick();
        send_item(MODE_TICK, ID_W'($urandom), 1'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic random_item();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            send_tick();
        else if (roll < 75)
            send_frame(reply_id, $urandom_range(4) == 0);
        else if (roll < 87)
            send_frame(group_id($urandom_range(7)), 1'($urandom));
        else
            send_frame(ID_W'($urandom), 1'($urandom));
    endtask

    // stop offering beats and wait until every predicted result is taken
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] cmd, input logic [15:0] pwr,
                             input logic [15:0] volt, input logic [15:0] curr,
                             input logic [7:0] tmo, input int send_gap, input int take_gap,
                             input int tick_burst, input int n_items, input int hold_at,
                             input int pause_at);
        settle();
        send_gap_pct = send_gap;
        take_gap_pct = take_gap;
        cfg_write(CFG_CMD, cmd);
        cfg_write(CFG_POWER, pwr);
        cfg_write(CFG_VOLTAGE, volt);
        cfg_write(CFG_CURRENT, curr);
        cfg_write(CFG_TIMEOUT, {8'h00, tmo});
        cfg_valid <= 1'b0;
        if (tick_burst > 0)
        begin
            // clear any stale reply flag so the burst runs into the timeout
            send_frame(11'h7FF, 1'b0);
            repeat (tick_burst) send_tick();
        end
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                hold_asked = hold_asked + 1;
            if (i == pause_at)
                settle();
            random_item();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // id 0 matches the reset pending id: stale flag advances at first wait
        send_item(MODE_FRAME, 11'h000, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick();
        send_tick();
        send_tick();
        send_item(MODE_FRAME, group_id(1), 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_item(MODE_FRAME, 11'h7FF, 1'b0, 16'h0000, 16'hFFFF, 16'h0000);
        send_tick();
        send_item(MODE_FRAME, group_id(1), 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_tick();
        for (int g = 0; g < 8; g++)
            send_item(MODE_FRAME, group_id(g), 1'b0, (g % 2) ? 16'hFFFF : 16'h0000,
                      (g % 2) ? 16'h0000 : 16'hFFFF, 16'hFFFF);
        send_tick();
        send_item(MODE_FRAME, group_id(2), 1'b0, 16'hA5A5, 16'h5A5A, 16'hFFFF);
        send_tick();

        run_phase(16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), 8'd1,
                  22, 47, 0, 325, NO_EVENT, NO_EVENT);
        run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'd255,
                  22, 47, 258, 70, NO_EVENT, NO_EVENT);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'd3,
                  47, 22, 0, 325, NO_EVENT, 150);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'd2,
                  47, 22, 0, 325, NO_EVENT, NO_EVENT);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom_range(40, 4)), 0, 0, 0, 325, 50, NO_EVENT);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'd100,
                  0, 0, 0, 325, NO_EVENT, NO_EVENT);

        settle();
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
